// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DTXE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, checked during reset as well.
`define DTXE_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- design/dtxe_pkg.sv -----
// Shared types and constants of the text extent engine.
package dtxe_pkg;

   // Glyph ROM geometry
   localparam int unsigned GLYPH_TABLE_BYTES = 267616;
   localparam int unsigned GLYPH_LIMIT       = GLYPH_TABLE_BYTES - 32;
   localparam int unsigned GB_BASE           = 8'ha1;
   localparam int unsigned GB_ROW            = 94;

   // Default depth of the decode queue
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   // Reset values of the mark registers
   localparam logic [6:0] SOFT_BREAK_RST = 7'd13;
   localparam logic [6:0] KEY_BREAK_RST  = 7'd10;
   localparam logic [6:0] END_MARK_RST   = 7'd26;

   // Configuration register indexes
   localparam logic [1:0] CSR_LINE_WIDTH_LIMIT = 2'd0;
   localparam logic [1:0] CSR_SOFT_BREAK_CODE  = 2'd1;
   localparam logic [1:0] CSR_KEY_BREAK_CODE   = 2'd2;
   localparam logic [1:0] CSR_END_MARK_CODE    = 2'd3;

   // One decoded byte: first character, optional second single, optional summary
   typedef struct packed {
      logic        start;   // first entry of a string: clear measures
      logic [15:0] budget;  // byte budget sampled on the first byte
      logic        dbl;     // first character is an ideograph (hi, lo)
      logic [7:0]  hi;      // first character code or ideograph lead byte
      logic [7:0]  lo;      // ideograph trail byte or second single code
      logic        two;     // a second single character follows
      logic        last;    // string end: summary follows
   } entry_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Back-end result sequencer
   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_SUMMARY
   } phase_type;

endpackage

// ----- design/dtxe_front.sv -----
// Front end: accepts text bytes, pairs double-byte codes, queues decoded entries.
module dtxe_front import dtxe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_text_byte,
   input  logic             req_string_end,
   input  logic [15:0]      req_byte_budget,
   input  queue_status_type q_status,
   output logic             push,
   output entry_type        push_data
);

   logic        held_valid_ff, held_valid_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        at_start_ff, at_start_in;
   logic        start_pend_ff, start_pend_in;
   logic [15:0] budget_ff, budget_in;
   logic        accept;
   logic        b_high;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign b_high    = req_text_byte[7];

   // Build the entry for this beat
   always_comb begin
      push_data.start  = start_pend_ff;
      push_data.budget = at_start_ff ? req_byte_budget : budget_ff;
      push_data.last   = req_string_end;
      push_data.lo     = req_text_byte;
      if (held_valid_ff) begin
         push_data.hi  = held_byte_ff;
         push_data.dbl = b_high;
         push_data.two = !b_high;
      end else begin
         push_data.hi  = req_text_byte;
         push_data.dbl = 1'b0;
         push_data.two = 1'b0;
      end
   end

   // A lone high byte mid-string is held and yields nothing yet
   assign push = accept && (held_valid_ff || !b_high || req_string_end);

   always_comb begin
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      at_start_in   = at_start_ff;
      start_pend_in = start_pend_ff;
      budget_in     = budget_ff;
      if (accept) begin
         held_valid_in = !held_valid_ff && b_high && !req_string_end;
         held_byte_in  = req_text_byte;
         at_start_in   = req_string_end;
         budget_in     = push_data.budget;
         if (push) begin
            start_pend_in = req_string_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_byte_ff  <= '0;
         at_start_ff   <= 1'b1;
         start_pend_ff <= 1'b1;
         budget_ff     <= '0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
         at_start_ff   <= at_start_in;
         start_pend_ff <= start_pend_in;
         budget_ff     <= budget_in;
      end
   end

endmodule

// ----- design/dtxe_queue.sv -----
// Small register FIFO of decoded entries between front and back end.
module dtxe_queue import dtxe_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_data,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type q_status
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head           = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/dtxe_back.sv -----
// Back end: measures characters, forms glyph and summary beats, output register.
module dtxe_back import dtxe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_write_data,
   input  entry_type        head,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_result_kind,
   output logic [18:0]      rsp_glyph_offset,
   output logic             rsp_double_byte,
   output logic             rsp_glyph_undefined,
   output logic [4:0]       rsp_char_width,
   output logic [15:0]      rsp_first_line_width,
   output logic [15:0]      rsp_text_height,
   output logic [15:0]      rsp_char_count,
   output logic             rsp_run_last
);

   // Configuration registers
   logic [15:0] limit_ff;
   logic [6:0]  soft_ff, key_ff, end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
         soft_ff  <= SOFT_BREAK_RST;
         key_ff   <= KEY_BREAK_RST;
         end_ff   <= END_MARK_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LINE_WIDTH_LIMIT: limit_ff <= csr_write_data;
            CSR_SOFT_BREAK_CODE:  soft_ff  <= csr_write_data[6:0];
            CSR_KEY_BREAK_CODE:   key_ff   <= csr_write_data[6:0];
            CSR_END_MARK_CODE:    end_ff   <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   // Measure state
   logic [15:0] budget_ff, budget_in, width_ff, width_in, fill_ff, fill_in;
   logic [15:0] height_ff, height_in, count_ff, count_in;
   logic        stopped_ff, stopped_in;

   phase_type phase_ff, phase_in;
   logic      go, last_slot, is_char;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in, dbl_ff, dbl_in, undef_ff, undef_in, rl_ff, rl_in;
   logic [18:0] off_ff, off_in;
   logic [4:0]  cw_ff, cw_in;
   logic [15:0] flw_ff, flw_in, hgt_ff, hgt_in, cnt_ff, cnt_in;

   assign go = !q_status.empty && (!rsp_valid_ff || rsp_ready);

   // Sequencer: which slot of the head entry goes out, and what follows it
   always_comb begin
      phase_in = phase_ff;
      if (go) begin
         unique case (phase_ff)
            PH_FIRST:   phase_in = head.two ? PH_SECOND : (head.last ? PH_SUMMARY : PH_FIRST);
            PH_SECOND:  phase_in = head.last ? PH_SUMMARY : PH_FIRST;
            PH_SUMMARY: phase_in = PH_FIRST;
            default:    phase_in = PH_FIRST;
         endcase
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_FIRST: begin
            last_slot = !head.two && !head.last;
            is_char   = 1'b1;
         end
         PH_SECOND: begin
            last_slot = !head.last;
            is_char   = 1'b1;
         end
         PH_SUMMARY: begin
            last_slot = 1'b1;
            is_char   = 1'b0;
         end
         default: begin
            last_slot = 1'b1;
            is_char   = 1'b0;
         end
      endcase
   end

   assign pop = go && last_slot;

   // Measures as seen before this character; a string start resets them
   logic [15:0] b_budget, b_width, b_fill, b_height, b_count;
   logic        b_stopped, use_start;

   assign use_start = (phase_ff == PH_FIRST) && head.start;

   always_comb begin
      if (use_start) begin
         b_budget  = head.budget;
         b_width   = '0;
         b_stopped = 1'b0;
         b_fill    = '0;
         b_height  = 16'd16;
         b_count   = '0;
      end else begin
         b_budget  = budget_ff;
         b_width   = width_ff;
         b_stopped = stopped_ff;
         b_fill    = fill_ff;
         b_height  = height_ff;
         b_count   = count_ff;
      end
   end

   // Character under work
   logic        is_dbl, mark, wrap;
   logic [7:0]  code;
   logic [4:0]  cw, step;
   logic [15:0] used, budget_dec;
   logic [16:0] width_sum, fill_sum, height_sum, count_sum;

   assign is_dbl = (phase_ff == PH_FIRST) && head.dbl;
   assign code   = (phase_ff == PH_FIRST) ? head.hi : head.lo;
   assign step   = is_dbl ? 5'd16 : 5'd8;
   assign cw     = (is_dbl || code == 8'hff) ? 5'd16 : 5'd8;
   assign mark   = !is_dbl && (code == {1'b0, soft_ff} || code == {1'b0, key_ff}
                               || code == {1'b0, end_ff});

   assign used       = is_dbl ? 16'd2 : 16'd1;
   assign budget_dec = (b_budget > used) ? b_budget - used : '0;
   assign width_sum  = {1'b0, b_width} + 17'(cw);
   assign fill_sum   = {1'b0, b_fill} + 17'(step);
   assign height_sum = {1'b0, b_height} + 17'd16;
   assign count_sum  = {1'b0, b_count} + 17'd1;
   assign wrap       = ((limit_ff != '0) && (fill_sum >= {1'b0, limit_ff})) || mark;

   // Measure update
   always_comb begin
      budget_in  = b_budget;
      width_in   = b_width;
      stopped_in = b_stopped;
      if (!b_stopped) begin
         if (mark || b_budget == '0) begin
            stopped_in = 1'b1;
         end else begin
            width_in = width_sum[16] ? 16'hffff : width_sum[15:0];
            if (!b_budget[15]) begin
               budget_in = budget_dec;
               if (budget_dec == '0) begin
                  stopped_in = 1'b1;
               end
            end
         end
      end
      if (wrap) begin
         height_in = height_sum[16] ? 16'hffff : height_sum[15:0];
         fill_in   = '0;
      end else begin
         height_in = b_height;
         fill_in   = fill_sum[16] ? 16'hffff : fill_sum[15:0];
      end
      count_in = count_sum[16] ? 16'hffff : count_sum[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff  <= '0;
         width_ff   <= '0;
         stopped_ff <= 1'b0;
         fill_ff    <= '0;
         height_ff  <= 16'd16;
         count_ff   <= '0;
      end else if (go && is_char) begin
         budget_ff  <= budget_in;
         width_ff   <= width_in;
         stopped_ff <= stopped_in;
         fill_ff    <= fill_in;
         height_ff  <= height_in;
         count_ff   <= count_in;
      end
   end

   // Glyph offset: ideograph row*94+cell, times 32
   logic signed [8:0]  hi_rel, lo_rel;
   logic signed [15:0] hi_ext, lo_ext, idx;
   logic        [19:0] off_dbl;
   logic               undef_dbl;

   assign hi_rel    = $signed({1'b0, head.hi}) - 9'(GB_BASE);
   assign lo_rel    = $signed({1'b0, head.lo}) - 9'(GB_BASE);
   assign hi_ext    = {{7{hi_rel[8]}}, hi_rel};
   assign lo_ext    = {{7{lo_rel[8]}}, lo_rel};
   assign idx       = 16'(hi_ext * $signed(16'(GB_ROW))) + lo_ext;
   assign off_dbl   = {idx[14:0], 5'b0};
   assign undef_dbl = idx[15] || ({1'b0, off_dbl} > 21'(GLYPH_LIMIT));

   // Result beat contents
   always_comb begin
      kind_in  = 1'b0;
      off_in   = '0;
      dbl_in   = 1'b0;
      undef_in = 1'b0;
      cw_in    = '0;
      flw_in   = '0;
      hgt_in   = '0;
      cnt_in   = '0;
      rl_in    = last_slot;
      if (!is_char) begin
         kind_in = 1'b1;
         flw_in  = width_ff;
         hgt_in  = height_ff;
         cnt_in  = count_ff;
      end else if (is_dbl) begin
         dbl_in   = 1'b1;
         undef_in = undef_dbl;
         off_in   = undef_dbl ? '0 : off_dbl[18:0];
         cw_in    = cw;
      end else begin
         off_in = {7'b0, code, 4'b0};
         cw_in  = cw;
      end
   end

   assign rsp_valid_in = go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         kind_ff  <= kind_in;
         off_ff   <= off_in;
         dbl_ff   <= dbl_in;
         undef_ff <= undef_in;
         cw_ff    <= cw_in;
         flw_ff   <= flw_in;
         hgt_ff   <= hgt_in;
         cnt_ff   <= cnt_in;
         rl_ff    <= rl_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = kind_ff;
   assign rsp_glyph_offset     = off_ff;
   assign rsp_double_byte      = dbl_ff;
   assign rsp_glyph_undefined  = undef_ff;
   assign rsp_char_width       = cw_ff;
   assign rsp_first_line_width = flw_ff;
   assign rsp_text_height      = hgt_ff;
   assign rsp_char_count       = cnt_ff;
   assign rsp_run_last         = rl_ff;

endmodule

// ----- design/dbcs_text_extent_engine_core.sv -----
// Top level of the text extent engine: front end, decode queue, back end.
//
// Usage: text bytes enter one per beat on the req_ channel (valid/ready), with
// req_string_end on the final byte of a string; req_byte_budget is sampled on a
// string's first byte. Each character gives a glyph beat on the rsp_ channel,
// the final byte also a summary beat; rsp_run_last flags the last beat of a byte.
// A high byte mid-string is held to pair it with the next byte.
// Throughput: one byte per cycle on the input while req_ready is high; the back
// end sends one result beat per cycle while the receiver keeps up, so a byte
// with two or three results keeps it busy longer, and the QUEUE_DEPTH entry
// queue absorbs the difference. When the queue is empty, an accepted byte is
// written into the queue and its result then into the output register.
// A receiver stall holds the output register; the back end then stops, the
// queue fills and req_ready drops once it is full.
// Reset (synchronous) empties the queue, drops rsp_valid, restores the mark codes
// to 13, 10 and 26 and the line width limit to zero. csr_ writes take effect at
// once; the user must make them only while the block is idle (not enforced).
module dbcs_text_extent_engine_core import dtxe_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_string_end,
   input  logic [15:0] req_byte_budget,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [18:0] rsp_glyph_offset,
   output logic        rsp_double_byte,
   output logic        rsp_glyph_undefined,
   output logic [4:0]  rsp_char_width,
   output logic [15:0] rsp_first_line_width,
   output logic [15:0] rsp_text_height,
   output logic [15:0] rsp_char_count,
   output logic        rsp_run_last
);

   queue_status_type q_status;
   entry_type        push_data, head;
   logic             push, pop;

   dtxe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_string_end  (req_string_end),
      .req_byte_budget (req_byte_budget),
      .q_status        (q_status),
      .push            (push),
      .push_data       (push_data)
   );

   dtxe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   dtxe_back u_back (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .head                 (head),
      .q_status             (q_status),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_glyph_offset     (rsp_glyph_offset),
      .rsp_double_byte      (rsp_double_byte),
      .rsp_glyph_undefined  (rsp_glyph_undefined),
      .rsp_char_width       (rsp_char_width),
      .rsp_first_line_width (rsp_first_line_width),
      .rsp_text_height      (rsp_text_height),
      .rsp_char_count       (rsp_char_count),
      .rsp_run_last         (rsp_run_last)
   );

endmodule

// ----- design/dtxe_checker.sv -----
// Port-level checker for the text extent engine, bound to the top level.
`include "assert_macros.svh"

module dtxe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_kind,
   input logic [18:0] rsp_glyph_offset,
   input logic        rsp_double_byte,
   input logic        rsp_glyph_undefined,
   input logic [4:0]  rsp_char_width,
   input logic        rsp_run_last
);

   // Reset leaves no beat pending and room to accept
   `DTXE_ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_valid && req_ready)

   // A stalled result beat stays offered
   `DTXE_ASSERT_NEXT(a_stall_hold, clock, rsp_valid && !rsp_ready && !reset, rsp_valid)

   // The summary always closes the run of its byte
   `DTXE_ASSERT_IMPLY(a_summary_last, clock, reset, rsp_valid && rsp_result_kind, rsp_run_last)

   // A glyph beat is 8 or 16 wide, ideographs always 16
   `DTXE_ASSERT_IMPLY(a_glyph_width, clock, reset, rsp_valid && !rsp_result_kind, (rsp_char_width == 5'd16) || (rsp_char_width == 5'd8 && !rsp_double_byte))

   // Only ideographs can be undefined, and then point at offset zero
   `DTXE_ASSERT_IMPLY(a_undef_zero, clock, reset, rsp_valid && rsp_glyph_undefined, rsp_double_byte && rsp_glyph_offset == 19'd0)

endmodule

bind dbcs_text_extent_engine_core dtxe_checker u_dtxe_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_result_kind     (rsp_result_kind),
   .rsp_glyph_offset    (rsp_glyph_offset),
   .rsp_double_byte     (rsp_double_byte),
   .rsp_glyph_undefined (rsp_glyph_undefined),
   .rsp_char_width      (rsp_char_width),
   .rsp_run_last        (rsp_run_last)
);
